>>> design/npsrch_pkg.sv
// Shared constants and helpers for the next odd prime search block.
// Used by npsrch_div and next_odd_prime_search; no dependencies.

package npsrch_pkg;

	// Candidate width; the search stays within 1 .. 2^WIDTH-1
	localparam int WIDTH = 32;

	// Trial divisor width: holds the largest divisor, one odd step past sqrt(2^WIDTH)
	localparam int DIV_W = (WIDTH + 1) / 2 + 1;

	// Iteration counter width for the bit-serial divider
	localparam int CNT_W = $clog2(WIDTH + 1);

	// Width of the stream value fields
	localparam int DATA_W = 32;

	// First candidate: low WIDTH bits of the start value, forced odd
	function automatic logic [WIDTH-1:0] seed_cand(input logic [DATA_W-1:0] value);
		logic [WIDTH+DATA_W-1:0] ext;
		ext = {{WIDTH{1'b0}}, value};
		return ext[WIDTH-1:0] | WIDTH'(1);
	endfunction

	// Candidate reported on the 32-bit result field (truncated when WIDTH is wider)
	function automatic logic [DATA_W-1:0] cand_to_data(input logic [WIDTH-1:0] cand);
		logic [WIDTH+DATA_W-1:0] ext;
		ext = {{DATA_W{1'b0}}, cand};
		return ext[DATA_W-1:0];
	endfunction

endpackage

>>> design/npsrch_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on npsrch_pkg for WIDTH and CNT_W.

module npsrch_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [npsrch_pkg::WIDTH-1:0]  dividend,
	input  logic [npsrch_pkg::WIDTH-1:0]  divisor,
	output logic                          done,
	output logic [npsrch_pkg::WIDTH-1:0]  quotient,
	output logic [npsrch_pkg::WIDTH-1:0]  remainder
);

	logic [npsrch_pkg::WIDTH-1:0] rem_q;
	logic [npsrch_pkg::WIDTH-1:0] quo_q;
	logic [npsrch_pkg::WIDTH-1:0] den_q;
	logic [npsrch_pkg::CNT_W-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [npsrch_pkg::WIDTH+1:0] trial;
	logic                         trial_neg;

	// Trial subtract of the divisor from the partial remainder with the next dividend bit
	assign trial     = {1'b0, rem_q, quo_q[npsrch_pkg::WIDTH-1]} - {2'b00, den_q};
	assign trial_neg = trial[npsrch_pkg::WIDTH+1];

	// Control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= npsrch_pkg::CNT_W'(npsrch_pkg::WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - npsrch_pkg::CNT_W'(1);
				if (cnt_q == npsrch_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (trial_neg) begin
				rem_q <= {rem_q[npsrch_pkg::WIDTH-2:0], quo_q[npsrch_pkg::WIDTH-1]};
				quo_q <= {quo_q[npsrch_pkg::WIDTH-2:0], 1'b0};
			end else begin
				rem_q <= trial[npsrch_pkg::WIDTH-1:0];
				quo_q <= {quo_q[npsrch_pkg::WIDTH-2:0], 1'b1};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> design/next_odd_prime_search.sv
// Top level of the next odd prime search block.
// Depends on npsrch_pkg and npsrch_div.

// One start value and direction go in, one result comes out. The block walks
// odd candidates from the start value (low bit forced to one) in steps of two
// and tests each by trial division with odd divisors 3, 5, 7, ... up to the
// square root. Every trial division runs on the bit-serial divider: launch,
// divider iterations, decision. A candidate c costs up to about sqrt(c)/2
// divisions, and the search time is the sum over all candidates passed before
// the first prime. One item is worked on at a time; the next start value is
// taken once the current result sits in the output register. found clears and
// the start value is echoed when the search would wrap past 2^WIDTH-1 or
// drop below 1. The value 2 is never returned.

module next_odd_prime_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] start_value
	input  logic [0:0]  s_tuser,   // [0] direction_down
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_value
	output logic [0:0]  m_tuser    // [0] found
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_NEXT   = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]                          state_q;
	logic [npsrch_pkg::WIDTH-1:0]        cand_q;
	logic [npsrch_pkg::DIV_W-1:0]        div_q;
	logic [npsrch_pkg::DATA_W-1:0]       start_q;
	logic                                down_q;
	logic                                found_q;
	logic                                m_tvalid_q;
	logic [npsrch_pkg::DATA_W-1:0]       m_tdata_q;
	logic                                m_found_q;

	logic                                div_start;
	logic                                div_done;
	logic [npsrch_pkg::WIDTH-1:0]        div_ext;
	logic [npsrch_pkg::WIDTH-1:0]        quotient;
	logic [npsrch_pkg::WIDTH-1:0]        remainder;
	logic                                in_xact;
	logic                                out_free;

	assign in_xact   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_LAUNCH);
	assign div_ext   = {{(npsrch_pkg::WIDTH - npsrch_pkg::DIV_W){1'b0}}, div_q};

	npsrch_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (cand_q),
		.divisor   (div_ext),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xact) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					// one is not prime: move on without dividing
					if (cand_q == npsrch_pkg::WIDTH'(1)) state_q <= ST_NEXT;
					else state_q <= ST_LAUNCH;
				end
				ST_LAUNCH: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (div_ext > quotient) state_q <= ST_DONE;
						else if (remainder == '0) state_q <= ST_NEXT;
						else state_q <= ST_LAUNCH;
					end
				end
				ST_NEXT: begin
					if (down_q && cand_q == npsrch_pkg::WIDTH'(1)) state_q <= ST_DONE;
					else if (!down_q && (&cand_q)) state_q <= ST_DONE;
					else state_q <= ST_CHECK;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Candidate, divisor and outcome
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					start_q <= s_tdata;
					down_q  <= s_tuser[0];
					cand_q  <= npsrch_pkg::seed_cand(s_tdata);
				end
			end
			ST_CHECK: begin
				div_q <= npsrch_pkg::DIV_W'(3);
			end
			ST_DIV: begin
				if (div_done) begin
					if (div_ext > quotient) found_q <= 1'b1;
					else div_q <= div_q + npsrch_pkg::DIV_W'(2);
				end
			end
			ST_NEXT: begin
				if (down_q && cand_q == npsrch_pkg::WIDTH'(1)) found_q <= 1'b0;
				else if (!down_q && (&cand_q)) found_q <= 1'b0;
				else if (down_q) cand_q <= cand_q - npsrch_pkg::WIDTH'(2);
				else cand_q <= cand_q + npsrch_pkg::WIDTH'(2);
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= found_q ? npsrch_pkg::cand_to_data(cand_q) : start_q;
			m_found_q <= found_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_found_q;

endmodule

>>> design/npsrch_chk.sv
// Port-level checks for next_odd_prime_search, attached by bind.
// Depends on the top level's ports only.

module npsrch_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one search at a time: input closes right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still open after a transaction");

	// Any prime reported is odd
	a_found_odd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[0])
		else $error("even value reported as prime");

	// A result cannot appear in the cycle right after an input transaction
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared without a search");

endmodule

bind next_odd_prime_search npsrch_chk u_npsrch_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
